[sv/mrc_pkg.sv]
// Shared types, codes and functions of the Modbus RTU reply checker.
package mrc_pkg;

  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned FUNC_W  = 7;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned CFG_W   = 11;

  localparam logic [LEN_W-1:0] LEN_MAX      = 12'hFFF;
  localparam logic [LEN_W-1:0] EXC_LEN      = 12'd5;
  localparam logic [CRC_W-1:0] CRC_INIT     = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY     = 16'hA001;
  localparam int unsigned      EXC_BIT      = 7;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_FUNC       = 2'd1,
    CFG_COUNT      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_ARM     = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_NONE    = 4'd0,
    ST_TAKEN   = 4'd1,
    ST_ARMED   = 4'd2,
    ST_BADREQ  = 4'd3,
    ST_BUSY    = 4'd4,
    ST_OK      = 4'd5,
    ST_ADDR    = 4'd6,
    ST_FUNC    = 4'd7,
    ST_EXC     = 4'd8,
    ST_EXCCRC  = 4'd9,
    ST_CRC     = 4'd10,
    ST_TIMEOUT = 4'd11,
    ST_UNEXP   = 4'd12
  } status_t;

  localparam logic [FUNC_W-1:0] FC_RD_COILS  = 7'd1;
  localparam logic [FUNC_W-1:0] FC_RD_INPUTS = 7'd2;
  localparam logic [FUNC_W-1:0] FC_RD_HOLD   = 7'd3;
  localparam logic [FUNC_W-1:0] FC_RD_INREG  = 7'd4;
  localparam logic [FUNC_W-1:0] FC_WR_COIL   = 7'd5;
  localparam logic [FUNC_W-1:0] FC_WR_REG    = 7'd6;
  localparam logic [FUNC_W-1:0] FC_DIAG      = 7'd8;
  localparam logic [FUNC_W-1:0] FC_WR_COILS  = 7'd15;
  localparam logic [FUNC_W-1:0] FC_WR_REGS   = 7'd16;

  typedef struct packed {
    logic [ADDR_W-1:0]  slave_addr;
    logic [FUNC_W-1:0]  func_code;
    logic [COUNT_W-1:0] item_count;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        exception_code;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

  // One byte of CRC-16, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Expected reply length; zero means the request cannot be armed.
  function automatic logic [LEN_W-1:0] reply_length(input logic [FUNC_W-1:0] fc,
                                                    input logic [COUNT_W-1:0] n);
    logic [LEN_W:0] len;
    logic [LEN_W:0] n_ext;
    n_ext = {2'b00, n};
    case (fc)
      FC_RD_COILS, FC_RD_INPUTS: len = 13'd5 + ((n_ext + 13'd7) >> 3);
      FC_RD_HOLD, FC_RD_INREG:   len = 13'd5 + {n_ext[LEN_W-1:0], 1'b0};
      FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: len = 13'd8;
      FC_DIAG:                   len = 13'd6 + {n_ext[LEN_W-1:0], 1'b0};
      default:                   len = '0;
    endcase
    return (len > {1'b0, LEN_MAX}) ? '0 : len[LEN_W-1:0];
  endfunction

endpackage

[sv/mrc_if.sv]
// Valid/ready channel interfaces for request beats and result beats.
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  exception_code;
  logic [11:0] frame_length;

  modport source (output valid, output status, output exception_code,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input exception_code,
                  input frame_length, output ready);
endinterface

[sv/mrc_cfg_regs.sv]
// Configuration registers of the reply checker.
module mrc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0] cfg_wdata,
  output mrc_pkg::cfg_t             cfg
);

  mrc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_addr <= 8'd1;
      cfg_r.func_code  <= 7'd3;
      cfg_r.item_count <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrc_pkg::CFG_SLAVE_ADDR: cfg_r.slave_addr <= cfg_wdata[mrc_pkg::ADDR_W-1:0];
        mrc_pkg::CFG_FUNC:       cfg_r.func_code  <= cfg_wdata[mrc_pkg::FUNC_W-1:0];
        mrc_pkg::CFG_COUNT:      cfg_r.item_count <= cfg_wdata[mrc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/mrc_step.sv]
// Transaction state and the per-beat verdict logic of the reply checker.
module mrc_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,
  input  logic [1:0]           req_type,
  input  logic [7:0]           rx_byte,
  input  mrc_pkg::cfg_t        cfg,
  output mrc_pkg::res_t        res
);

  logic                          await_r, await_nxt;
  logic [mrc_pkg::LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [mrc_pkg::CRC_W-1:0]     crc_r, crc_nxt;
  logic [mrc_pkg::LEN_W-1:0]     exp_len_r, exp_len_nxt;
  logic [7:0]                    b1_r, b1_nxt;
  logic [7:0]                    b2_r, b2_nxt;
  logic [7:0]                    b3_r, b3_nxt;
  logic [mrc_pkg::LEN_W-1:0]     arm_len;
  logic                          exc_bit;

  assign arm_len = mrc_pkg::reply_length(cfg.func_code, cfg.item_count);

  always_comb begin
    await_nxt   = await_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    exp_len_nxt = exp_len_r;
    b1_nxt      = b1_r;
    b2_nxt      = b2_r;
    b3_nxt      = b3_r;
    exc_bit     = 1'b0;
    res.status         = mrc_pkg::ST_NONE;
    res.exception_code = '0;
    res.frame_length   = '0;
    unique case (req_type)
      mrc_pkg::REQ_ARM: begin
        if (await_r) begin
          res.status = mrc_pkg::ST_BUSY;
        end else if (arm_len == '0) begin
          res.status = mrc_pkg::ST_BADREQ;
        end else begin
          exp_len_nxt = arm_len;
          cnt_nxt     = '0;
          crc_nxt     = mrc_pkg::CRC_INIT;
          b1_nxt      = '0;
          b2_nxt      = '0;
          b3_nxt      = '0;
          await_nxt   = 1'b1;
          res.status  = mrc_pkg::ST_ARMED;
        end
      end
      mrc_pkg::REQ_TIMEOUT: begin
        if (await_r) begin
          res.status       = mrc_pkg::ST_TIMEOUT;
          res.frame_length = cnt_r;
          await_nxt        = 1'b0;
        end
      end
      mrc_pkg::REQ_BYTE: begin
        if (!await_r) begin
          res.status = mrc_pkg::ST_UNEXP;
        end else begin
          if (cnt_r != mrc_pkg::LEN_MAX) begin
            cnt_nxt = cnt_r + 12'd1;
          end
          if (cnt_nxt == 12'd1) begin
            b1_nxt = rx_byte;
          end else if (cnt_nxt == 12'd2) begin
            b2_nxt = rx_byte;
          end else if (cnt_nxt == 12'd3) begin
            b3_nxt = rx_byte;
          end
          crc_nxt = mrc_pkg::crc_feed(crc_r, rx_byte);
          exc_bit = b2_nxt[mrc_pkg::EXC_BIT];
          if (cnt_nxt >= mrc_pkg::EXC_LEN && (exc_bit || cnt_nxt >= exp_len_r)) begin
            res.frame_length = cnt_nxt;
            await_nxt        = 1'b0;
            priority if (b1_nxt != cfg.slave_addr) begin
              res.status = mrc_pkg::ST_ADDR;
            end else if (b2_nxt[mrc_pkg::FUNC_W-1:0] != cfg.func_code) begin
              res.status = mrc_pkg::ST_FUNC;
            end else if (exc_bit) begin
              if (crc_nxt == '0) begin
                res.status         = mrc_pkg::ST_EXC;
                res.exception_code = b3_nxt;
              end else begin
                res.status = mrc_pkg::ST_EXCCRC;
              end
            end else begin
              res.status = (crc_nxt == '0) ? mrc_pkg::ST_OK : mrc_pkg::ST_CRC;
            end
          end else begin
            res.status = mrc_pkg::ST_TAKEN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b0;
      cnt_r     <= '0;
      crc_r     <= mrc_pkg::CRC_INIT;
      exp_len_r <= '0;
      b1_r      <= '0;
      b2_r      <= '0;
      b3_r      <= '0;
    end else if (proc) begin
      await_r   <= await_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      exp_len_r <= exp_len_nxt;
      b1_r      <= b1_nxt;
      b2_r      <= b2_nxt;
      b3_r      <= b3_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (cnt_r < exp_len_r))
    else $error("byte count reached the expected length while still awaiting");
`endif

endmodule

[sv/modbus_rtu_reply_checker_core.sv]
// Top level of the Modbus RTU reply checker.
// Each request beat (received byte, timeout tick or arm) produces exactly one result
// beat. A beat is held in an input register, evaluated combinationally against the
// transaction state and a one-byte CRC-16 update, and written to a result register;
// throughput is one beat per clock while the result channel is not stalled.
// Configuration must be written only while no beat is in flight, as a write takes
// effect at once on any beat still held.
module modbus_rtu_reply_checker_core (
  input  logic                      clk,
  input  logic                      rst_n,
  mrc_in_if.sink                    in_ch,
  mrc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0] cfg_wdata
);

  mrc_pkg::cfg_t cfg;
  mrc_pkg::res_t res;
  mrc_pkg::res_t res_r;
  logic          in_vld_r;
  logic [1:0]    req_r;
  logic [7:0]    byte_r;
  logic          out_vld_r;
  logic          proc;

  mrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mrc_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .req_type (req_r),
    .rx_byte  (byte_r),
    .cfg      (cfg),
    .res      (res)
  );

  assign proc        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r  <= in_ch.req_type;
      byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.exception_code = res_r.exception_code;
  assign out_ch.frame_length   = res_r.frame_length;

`ifndef SYNTHESIS
  a_verdict_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status != mrc_pkg::ST_TIMEOUT
     && res_r.status >= mrc_pkg::ST_OK && res_r.status <= mrc_pkg::ST_CRC)
    |-> (res_r.frame_length >= mrc_pkg::EXC_LEN))
    else $error("frame verdict given before five bytes");
`endif

`ifndef SYNTHESIS
  a_exc_code_only_on_exc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status != mrc_pkg::ST_EXC) |-> (res_r.exception_code == '0))
    else $error("exception code set outside an exception verdict");
`endif

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_ch.ready) |=> (in_vld_r && $stable(req_r)
     && $stable(byte_r)))
    else $error("held request beat lost while the result beat was stalled");
`endif

endmodule
